>>> hdl/bpa_pkg.sv
package bpa_pkg;

    // Default geometry.
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int MAX_ORDER_DEF  = 10;
    localparam int PAGE_SHIFT_DEF = 12;

    // Fixed field widths.
    localparam int BYTES_W = 23;
    localparam int INDEX_W = 10;
    localparam int STAT_W  = 2;
    localparam int BORD_W  = 4;
    localparam int ORD_W   = 5;

    localparam logic [ORD_W-1:0] NOT_HEAD = 5'd31;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOBLOCK = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_ORD,
        S_A_SRCH,
        S_SPL_RD,
        S_SPL_W1,
        S_SPL_W2,
        S_POP_RD,
        S_POP_WR,
        S_F_RD,
        S_F_CHK,
        S_M_CHK,
        S_M_BUD,
        S_M_POPC,
        S_M_BNX,
        S_M_WALK,
        S_M_W1,
        S_M_W2
    } t_state;

    // Position of the highest set bit; zero for zero.
    function automatic logic [ORD_W-1:0] f_flog2(input logic [31:0] v);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) begin
                k = ORD_W'(b);
            end
        end
        return k;
    endfunction

endpackage

>>> hdl/buddy_page_allocator_unit.sv
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         i_opcode, i_request_bytes, i_block_index
// result    out        o_valid, one cycle    o_status, o_start_page, o_block_order
//
// After reset a sweep over all NUM_PAGES pages builds the initial blocks; busy stays high.
// An allocate finds the order, searches the free lists upward, splits a larger block down
// and pops the block. A free checks the block, then merges with free buddies, walking
// the free list to unlink each buddy through the single read port of the link memory.
// Reset is synchronous and active low. The result strobe cannot be stalled.
module buddy_page_allocator_unit #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [bpa_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [bpa_pkg::INDEX_W-1:0]  i_block_index,
    output logic                         o_valid,
    output logic [bpa_pkg::STAT_W-1:0]   o_status,
    output logic [bpa_pkg::INDEX_W-1:0]  o_start_page,
    output logic [bpa_pkg::BORD_W-1:0]   o_block_order
);

    localparam int PW    = $clog2(NUM_PAGES);
    localparam int LW    = $clog2(NUM_PAGES + 1);
    localparam int TW    = $clog2(MAX_ORDER + 1);
    localparam int OW    = bpa_pkg::ORD_W;
    localparam int AW    = OW + 1;
    localparam int PGW   = bpa_pkg::BYTES_W + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    bpa_pkg::t_state r_state, n_state;
    logic                        r_op, n_op;
    logic [PGW-1:0]              r_pages, n_pages;
    logic [bpa_pkg::INDEX_W-1:0] r_idx, n_idx;
    logic [OW-1:0]               r_ord, n_ord;
    logic [OW-1:0]               r_j, n_j;
    logic [OW-1:0]               r_o, n_o;
    logic [LW-1:0]               r_h, n_h;
    logic [LW-1:0]               r_cur, n_cur;
    logic [LW-1:0]               r_buddy, n_buddy;
    logic [LW-1:0]               r_walk, n_walk;
    logic [LW-1:0]               r_bnext, n_bnext;
    logic [LW-1:0]               r_top [MAX_ORDER+1];
    logic [LW-1:0]               n_top [MAX_ORDER+1];
    logic [LW-1:0]               r_i, n_i;
    logic [LW-1:0]               r_ihead, n_ihead;
    logic [LW-1:0]               r_iprev, n_iprev;
    logic                        r_valid, n_valid;
    logic [bpa_pkg::STAT_W-1:0]  r_status, n_status;
    logic [bpa_pkg::INDEX_W-1:0] r_page, n_page;
    logic [bpa_pkg::BORD_W-1:0]  r_bord, n_bord;

    // Order/allocated memory and free-list link memory.
    logic          a_we, b_we;
    logic [PW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [AW-1:0] a_wdata, a_rdata;
    logic [LW-1:0] b_wdata, b_rdata;

    bpa_ram #(.W(AW), .D(NUM_PAGES)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    bpa_ram #(.W(LW), .D(NUM_PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    logic [31:0]   w_rem;
    logic [OW-1:0] w_k;
    logic          w_ihead;
    logic [OW-1:0] w_jm1, w_op1;
    logic [31:0]   w_bud;
    logic [LW-1:0] w_low, w_high;
    logic [OW-1:0] w_rd_ord;
    logic          w_rd_alloc;

    always_comb begin
        w_rem      = 32'(NUM_PAGES) - 32'(r_i);
        w_k        = (w_rem >= (32'd1 << MAX_ORDER)) ? OW'(MAX_ORDER)
                                                    : bpa_pkg::f_flog2(w_rem);
        w_ihead    = (r_i == r_ihead);
        w_jm1      = r_j - 1'b1;
        w_op1      = r_o + 1'b1;
        w_bud      = 32'(r_cur) ^ (32'd1 << r_o);
        w_low      = (r_cur < r_buddy) ? r_cur : r_buddy;
        w_high     = (r_cur < r_buddy) ? r_buddy : r_cur;
        w_rd_ord   = a_rdata[OW-1:0];
        w_rd_alloc = a_rdata[OW];
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pages  = r_pages;
        n_idx    = r_idx;
        n_ord    = r_ord;
        n_j      = r_j;
        n_o      = r_o;
        n_h      = r_h;
        n_cur    = r_cur;
        n_buddy  = r_buddy;
        n_walk   = r_walk;
        n_bnext  = r_bnext;
        n_top    = r_top;
        n_i      = r_i;
        n_ihead  = r_ihead;
        n_iprev  = r_iprev;
        n_valid  = 1'b0;
        n_status = r_status;
        n_page   = r_page;
        n_bord   = r_bord;
        a_we     = 1'b0;
        a_waddr  = '0;
        a_wdata  = '0;
        a_raddr  = '0;
        b_we     = 1'b0;
        b_waddr  = '0;
        b_wdata  = '0;
        b_raddr  = '0;

        unique case (r_state)
            bpa_pkg::S_INIT: begin
                a_we    = 1'b1;
                a_waddr = PW'(r_i);
                a_wdata = {1'b0, w_ihead ? w_k : bpa_pkg::NOT_HEAD};
                b_we    = 1'b1;
                b_waddr = PW'(r_i);
                b_wdata = (w_ihead && w_k == OW'(MAX_ORDER)) ? r_iprev : NIL;
                if (w_ihead) begin
                    n_top[w_k[TW-1:0]] = r_i;
                    n_ihead = LW'(32'(r_i) + (32'd1 << w_k));
                    if (w_k == OW'(MAX_ORDER)) begin
                        n_iprev = r_i;
                    end
                end
                n_i = r_i + 1'b1;
                if (r_i == LW'(NUM_PAGES - 1)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_pages = (PGW'(i_request_bytes) + PGW'((1 << PAGE_SHIFT) - 1))
                              >> PAGE_SHIFT;
                    n_idx   = i_block_index;
                    n_ord   = '0;
                    n_state = (i_opcode == bpa_pkg::OP_ALLOC) ? bpa_pkg::S_A_ORD
                                                               : bpa_pkg::S_F_RD;
                end
            end
            bpa_pkg::S_A_ORD: begin
                if (r_ord > OW'(MAX_ORDER)) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_NOBLOCK;
                    n_page   = '0;
                    n_bord   = '0;
                    n_state  = bpa_pkg::S_IDLE;
                end else if (((PGW+1)'(1) << r_ord) < {1'b0, r_pages}) begin
                    n_ord = r_ord + 1'b1;
                end else begin
                    n_j     = r_ord;
                    n_state = bpa_pkg::S_A_SRCH;
                end
            end
            bpa_pkg::S_A_SRCH: begin
                if (r_j > OW'(MAX_ORDER)) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_NOBLOCK;
                    n_page   = '0;
                    n_bord   = '0;
                    n_state  = bpa_pkg::S_IDLE;
                end else if (r_top[r_j[TW-1:0]] == NIL) begin
                    n_j = r_j + 1'b1;
                end else if (r_j == r_ord) begin
                    n_state = bpa_pkg::S_POP_RD;
                end else begin
                    n_state = bpa_pkg::S_SPL_RD;
                end
            end
            bpa_pkg::S_SPL_RD: begin
                n_h     = r_top[r_j[TW-1:0]];
                b_raddr = PW'(r_top[r_j[TW-1:0]]);
                n_state = bpa_pkg::S_SPL_W1;
            end
            bpa_pkg::S_SPL_W1: begin
                // Pop the block and push its lower half one order down.
                n_top[r_j[TW-1:0]]   = b_rdata;
                b_we                 = 1'b1;
                b_waddr              = PW'(r_h);
                b_wdata              = r_top[w_jm1[TW-1:0]];
                a_we                 = 1'b1;
                a_waddr              = PW'(r_h);
                a_wdata              = {1'b0, w_jm1};
                n_top[w_jm1[TW-1:0]] = r_h;
                n_state              = bpa_pkg::S_SPL_W2;
            end
            bpa_pkg::S_SPL_W2: begin
                b_we                 = 1'b1;
                b_waddr              = PW'(r_h) + (PW'(1) << w_jm1);
                b_wdata              = r_h;
                a_we                 = 1'b1;
                a_waddr              = PW'(r_h) + (PW'(1) << w_jm1);
                a_wdata              = {1'b0, w_jm1};
                n_top[w_jm1[TW-1:0]] = LW'(PW'(r_h) + (PW'(1) << w_jm1));
                n_j                  = w_jm1;
                n_state = (w_jm1 == r_ord) ? bpa_pkg::S_POP_RD : bpa_pkg::S_SPL_RD;
            end
            bpa_pkg::S_POP_RD: begin
                n_h     = r_top[r_ord[TW-1:0]];
                b_raddr = PW'(r_top[r_ord[TW-1:0]]);
                n_state = bpa_pkg::S_POP_WR;
            end
            bpa_pkg::S_POP_WR: begin
                n_top[r_ord[TW-1:0]] = b_rdata;
                a_we     = 1'b1;
                a_waddr  = PW'(r_h);
                a_wdata  = {1'b1, r_ord};
                n_valid  = 1'b1;
                n_status = bpa_pkg::ST_OK;
                n_page   = bpa_pkg::INDEX_W'(r_h);
                n_bord   = bpa_pkg::BORD_W'(r_ord);
                n_state  = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_F_RD: begin
                if (32'(r_idx) >= 32'(NUM_PAGES)) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_BADFREE;
                    n_page   = '0;
                    n_bord   = '0;
                    n_state  = bpa_pkg::S_IDLE;
                end else begin
                    a_raddr = PW'(r_idx);
                    n_state = bpa_pkg::S_F_CHK;
                end
            end
            bpa_pkg::S_F_CHK: begin
                if (w_rd_ord > OW'(MAX_ORDER) || !w_rd_alloc) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_BADFREE;
                    n_page   = '0;
                    n_bord   = '0;
                    n_state  = bpa_pkg::S_IDLE;
                end else begin
                    a_we    = 1'b1;
                    a_waddr = PW'(r_idx);
                    a_wdata = {1'b0, w_rd_ord};
                    b_we    = 1'b1;
                    b_waddr = PW'(r_idx);
                    b_wdata = r_top[w_rd_ord[TW-1:0]];
                    n_top[w_rd_ord[TW-1:0]] = LW'(r_idx);
                    n_cur   = LW'(r_idx);
                    n_o     = w_rd_ord;
                    n_ord   = w_rd_ord;
                    n_state = bpa_pkg::S_M_CHK;
                end
            end
            bpa_pkg::S_M_CHK: begin
                if (r_o >= OW'(MAX_ORDER) || w_bud >= 32'(NUM_PAGES)) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_OK;
                    n_page   = r_idx;
                    n_bord   = bpa_pkg::BORD_W'(r_ord);
                    n_state  = bpa_pkg::S_IDLE;
                end else begin
                    n_buddy = LW'(w_bud);
                    a_raddr = PW'(w_bud);
                    n_state = bpa_pkg::S_M_BUD;
                end
            end
            bpa_pkg::S_M_BUD: begin
                if (w_rd_ord != r_o || w_rd_alloc) begin
                    n_valid  = 1'b1;
                    n_status = bpa_pkg::ST_OK;
                    n_page   = r_idx;
                    n_bord   = bpa_pkg::BORD_W'(r_ord);
                    n_state  = bpa_pkg::S_IDLE;
                end else begin
                    b_raddr = PW'(r_cur);
                    n_state = bpa_pkg::S_M_POPC;
                end
            end
            bpa_pkg::S_M_POPC: begin
                // The current block was pushed last, so it sits at the top.
                n_top[r_o[TW-1:0]] = b_rdata;
                n_walk  = b_rdata;
                b_raddr = PW'(r_buddy);
                n_state = bpa_pkg::S_M_BNX;
            end
            bpa_pkg::S_M_BNX: begin
                n_bnext = b_rdata;
                if (r_walk == r_buddy) begin
                    n_top[r_o[TW-1:0]] = b_rdata;
                    n_state = bpa_pkg::S_M_W1;
                end else if (r_walk == NIL) begin
                    n_state = bpa_pkg::S_M_W1;
                end else begin
                    b_raddr = PW'(r_walk);
                    n_state = bpa_pkg::S_M_WALK;
                end
            end
            bpa_pkg::S_M_WALK: begin
                if (b_rdata == r_buddy) begin
                    b_we    = 1'b1;
                    b_waddr = PW'(r_walk);
                    b_wdata = r_bnext;
                    n_state = bpa_pkg::S_M_W1;
                end else if (b_rdata == NIL) begin
                    n_state = bpa_pkg::S_M_W1;
                end else begin
                    n_walk  = b_rdata;
                    b_raddr = PW'(b_rdata);
                end
            end
            bpa_pkg::S_M_W1: begin
                a_we    = 1'b1;
                a_waddr = PW'(w_high);
                a_wdata = {1'b0, bpa_pkg::NOT_HEAD};
                b_we    = 1'b1;
                b_waddr = PW'(w_low);
                b_wdata = r_top[w_op1[TW-1:0]];
                n_top[w_op1[TW-1:0]] = w_low;
                n_cur   = w_low;
                n_state = bpa_pkg::S_M_W2;
            end
            bpa_pkg::S_M_W2: begin
                a_we    = 1'b1;
                a_waddr = PW'(r_cur);
                a_wdata = {1'b0, w_op1};
                n_o     = w_op1;
                n_state = bpa_pkg::S_M_CHK;
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_INIT;
            r_valid <= 1'b0;
            r_i     <= '0;
            r_ihead <= '0;
            r_iprev <= NIL;
            for (int t = 0; t <= MAX_ORDER; t++) begin
                r_top[t] <= NIL;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_i     <= n_i;
            r_ihead <= n_ihead;
            r_iprev <= n_iprev;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pages  <= n_pages;
        r_idx    <= n_idx;
        r_ord    <= n_ord;
        r_j      <= n_j;
        r_o      <= n_o;
        r_h      <= n_h;
        r_cur    <= n_cur;
        r_buddy  <= n_buddy;
        r_walk   <= n_walk;
        r_bnext  <= n_bnext;
        r_status <= n_status;
        r_page   <= n_page;
        r_bord   <= n_bord;
    end

    assign busy          = (r_state != bpa_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_start_page  = r_page;
    assign o_block_order = r_bord;

`ifndef SYNTHESIS
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) != bpa_pkg::S_IDLE && $past(r_state) != bpa_pkg::S_INIT)
        else $error("result strobe without a command in progress");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bpa_pkg::ST_OK |-> o_start_page == '0 && o_block_order == '0)
        else $error("failure result carries a block");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bpa_pkg::ST_OK |-> 32'(o_block_order) <= 32'(MAX_ORDER))
        else $error("reported order above the maximum");

    a_free_requires_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_F_CHK |-> r_op == bpa_pkg::OP_FREE)
        else $error("free path entered for an allocate");
`endif

endmodule

>>> hdl/bpa_ram.sv
module bpa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPG      = bpa_pkg::NUM_PAGES_DEF;
    localparam int MAXO     = bpa_pkg::MAX_ORDER_DEF;
    localparam int PSHIFT   = bpa_pkg::PAGE_SHIFT_DEF;
    localparam int NIL      = NPG;
    localparam int WD_LIMIT = 20000;
    localparam int N_RAND   = 1100;

    typedef struct packed {
        logic                         opcode;
        logic [bpa_pkg::BYTES_W-1:0]  req_bytes;
        logic [bpa_pkg::INDEX_W-1:0]  blk_index;
    } t_cmd;

    typedef struct packed {
        logic [bpa_pkg::STAT_W-1:0]   status;
        logic [bpa_pkg::INDEX_W-1:0]  page;
        logic [bpa_pkg::BORD_W-1:0]   order;
    } t_rsp;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_opcode;
    logic [bpa_pkg::BYTES_W-1:0]   i_request_bytes;
    logic [bpa_pkg::INDEX_W-1:0]   i_block_index;
    logic                          o_valid;
    logic [bpa_pkg::STAT_W-1:0]    o_status;
    logic [bpa_pkg::INDEX_W-1:0]   o_start_page;
    logic [bpa_pkg::BORD_W-1:0]    o_block_order;

    buddy_page_allocator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_request_bytes(i_request_bytes),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_start_page   (o_start_page),
        .o_block_order  (o_block_order)
    );

    // Shadow allocator state.
    logic [4:0] pg_order [NPG];
    logic       pg_alloc [NPG];
    int         fl_next  [NPG];
    int         fl_top   [MAXO+1];
    int         live_heads[$];

    t_cmd cmd_queue[$];
    t_rsp expected_rsp[$];
    int   n_errors;
    int   n_sent;
    int   n_fail;
    int   gap_left;
    int   idle_cycles;

    function automatic void fl_push(int ord, int head);
        fl_next[head] = fl_top[ord];
        fl_top[ord]   = head;
    endfunction

    function automatic int fl_pop(int ord);
        int head;
        head        = fl_top[ord];
        fl_top[ord] = fl_next[head];
        fl_next[head] = NIL;
        return head;
    endfunction

    function automatic void fl_unlink(int ord, int head);
        int cur;
        cur = fl_top[ord];
        if (cur == head) begin
            fl_top[ord]   = fl_next[head];
            fl_next[head] = NIL;
            return;
        end
        while (cur != NIL) begin
            if (fl_next[cur] == head) begin
                fl_next[cur]  = fl_next[head];
                fl_next[head] = NIL;
                return;
            end
            cur = fl_next[cur];
        end
    endfunction

    function automatic void pool_init();
        int base;
        int left;
        int k;
        for (int i = 0; i < NPG; i++) begin
            pg_order[i] = bpa_pkg::NOT_HEAD;
            pg_alloc[i] = 1'b0;
            fl_next[i]  = NIL;
        end
        for (int i = 0; i <= MAXO; i++) begin
            fl_top[i] = NIL;
        end
        base = 0;
        left = NPG;
        while (left > 0) begin
            k = 0;
            while (k < MAXO && (2 << k) <= left) k++;
            pg_order[base] = 5'(k);
            fl_push(k, base);
            base += 1 << k;
            left -= 1 << k;
        end
    endfunction

    function automatic t_rsp allocate_block(logic [bpa_pkg::BYTES_W-1:0] nbytes);
        t_rsp r;
        longint pages;
        int ord;
        int j;
        int h;
        int upper;
        r = '{status: bpa_pkg::ST_NOBLOCK, page: '0, order: '0};
        pages = (longint'(nbytes) + (1 << PSHIFT) - 1) >> PSHIFT;
        ord = 0;
        while (ord <= MAXO && (longint'(1) << ord) < pages) ord++;
        if (ord > MAXO) return r;
        j = ord;
        while (j <= MAXO && fl_top[j] == NIL) j++;
        if (j > MAXO) return r;
        while (j > ord) begin
            h = fl_pop(j);
            upper = h + (1 << (j - 1));
            j--;
            pg_order[h]     = 5'(j);
            pg_order[upper] = 5'(j);
            fl_push(j, h);
            fl_push(j, upper);
        end
        h = fl_pop(ord);
        pg_alloc[h] = 1'b1;
        live_heads.push_back(h);
        r = '{status: bpa_pkg::ST_OK, page: bpa_pkg::INDEX_W'(h),
              order: bpa_pkg::BORD_W'(ord)};
        return r;
    endfunction

    function automatic t_rsp free_block(logic [bpa_pkg::INDEX_W-1:0] idx);
        t_rsp r;
        int ord;
        int cur;
        int o;
        int bud;
        int low;
        r = '{status: bpa_pkg::ST_BADFREE, page: '0, order: '0};
        if (int'(idx) >= NPG) return r;
        ord = pg_order[idx];
        if (ord > MAXO || !pg_alloc[idx]) return r;
        pg_alloc[idx] = 1'b0;
        foreach (live_heads[i]) begin
            if (live_heads[i] == int'(idx)) begin
                live_heads.delete(i);
                break;
            end
        end
        fl_push(ord, idx);
        cur = idx;
        while (pg_order[cur] < MAXO) begin
            o = pg_order[cur];
            bud = cur ^ (1 << o);
            if (bud >= NPG || pg_order[bud] != o || pg_alloc[bud]) break;
            fl_unlink(o, cur);
            fl_unlink(o, bud);
            low = (cur < bud) ? cur : bud;
            pg_order[cur ^ bud ^ low] = bpa_pkg::NOT_HEAD;
            pg_order[low] = 5'(o + 1);
            fl_push(o + 1, low);
            cur = low;
        end
        r = '{status: bpa_pkg::ST_OK, page: idx, order: bpa_pkg::BORD_W'(ord)};
        return r;
    endfunction

    function automatic t_cmd mk_alloc(int nbytes);
        t_cmd c;
        c.opcode = bpa_pkg::OP_ALLOC;
        c.req_bytes = bpa_pkg::BYTES_W'(nbytes);
        c.blk_index = bpa_pkg::INDEX_W'($urandom);
        return c;
    endfunction

    function automatic t_cmd mk_free(int idx);
        t_cmd c;
        c.opcode = bpa_pkg::OP_FREE;
        c.req_bytes = bpa_pkg::BYTES_W'($urandom);
        c.blk_index = bpa_pkg::INDEX_W'(idx);
        return c;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Directed part: extremes of the request, split chains, merges and bad frees.
    initial begin
        cmd_queue.push_back(mk_alloc(0));
        cmd_queue.push_back(mk_alloc(1));
        cmd_queue.push_back(mk_alloc(4096));
        cmd_queue.push_back(mk_alloc(4097));
        cmd_queue.push_back(mk_alloc(4194304));
        cmd_queue.push_back(mk_alloc(4194305));
        cmd_queue.push_back(mk_alloc(8388607));
        cmd_queue.push_back(mk_free(0));
        cmd_queue.push_back(mk_free(0));
        cmd_queue.push_back(mk_free(1));
        cmd_queue.push_back(mk_free(3));
        cmd_queue.push_back(mk_free(2));
        cmd_queue.push_back(mk_free(1023));
        cmd_queue.push_back(mk_free(512));
        cmd_queue.push_back(mk_alloc(4194304));
        cmd_queue.push_back(mk_alloc(4096));
        cmd_queue.push_back(mk_free(0));
        cmd_queue.push_back(mk_alloc(2097152));
        cmd_queue.push_back(mk_alloc(2097152));
        cmd_queue.push_back(mk_alloc(1));
        cmd_queue.push_back(mk_free(512));
        cmd_queue.push_back(mk_free(0));
        cmd_queue.push_back(mk_free(768));
    end

    // Driver: random items are built at issue time so that frees can target live blocks.
    always @(posedge i_clk) begin
        t_cmd c;
        int sel;
        int ord;
        if (!i_rst_n) begin
            start           <= 1'b0;
            i_opcode        <= bpa_pkg::OP_ALLOC;
            i_request_bytes <= '0;
            i_block_index   <= '0;
            gap_left        <= 0;
        end else if (start && !busy) begin
            start    <= 1'b0;
            gap_left <= pick_gap();
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (cmd_queue.size() > 0 || n_sent < N_RAND + 23) begin
                if (cmd_queue.size() > 0) begin
                    c = cmd_queue.pop_front();
                end else begin
                    sel = $urandom_range(0, 99);
                    if (sel < 45 || (sel < 60 && live_heads.size() < 4)) begin
                        ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10)
                                                          : $urandom_range(0, 4);
                        c = mk_alloc($urandom_range(0, (1 << ord) << PSHIFT));
                    end else if (sel < 88 && live_heads.size() > 0) begin
                        c = mk_free(live_heads[$urandom_range(0, live_heads.size() - 1)]);
                    end else if (sel < 94) begin
                        c = mk_free($urandom_range(0, NPG - 1));
                    end else begin
                        c = mk_alloc($urandom_range(0, (1 << bpa_pkg::BYTES_W) - 1));
                    end
                end
                if (c.opcode == bpa_pkg::OP_ALLOC) begin
                    expected_rsp.push_back(allocate_block(c.req_bytes));
                end else begin
                    expected_rsp.push_back(free_block(c.blk_index));
                end
                n_sent++;
                start           <= 1'b1;
                i_opcode        <= c.opcode;
                i_request_bytes <= c.req_bytes;
                i_block_index   <= c.blk_index;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (i_rst_n && o_valid) begin
            got = '{status: o_status, page: o_start_page, order: o_block_order};
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                n_errors++;
            end else begin
                exp_r = expected_rsp.pop_front();
                if (got.status != exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, got.status);
                    n_errors++;
                end
                if (got.page != exp_r.page) begin
                    $display("%0t: start_page expected %0d actual %0d",
                             $time, exp_r.page, got.page);
                    n_errors++;
                end
                if (got.order != exp_r.order) begin
                    $display("%0t: block_order expected %0d actual %0d",
                             $time, exp_r.order, got.order);
                    n_errors++;
                end
                if (exp_r.status != bpa_pkg::ST_OK) n_fail++;
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_rsp.size());
            $display("[buddy_page_allocator_unit] ERROR");
            $finish;
        end
    end

    initial begin
        n_errors    = 0;
        n_sent      = 0;
        n_fail      = 0;
        idle_cycles = 0;
        pool_init();
        @(posedge i_rst_n);
        wait (n_sent >= N_RAND + 23 && cmd_queue.size() == 0 && !start);
        wait (expected_rsp.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d allocate/free commands; %0d results were failure statuses.",
                 n_sent, n_fail);
        $display("Blocks still held at the end: %0d.", live_heads.size());
        if (n_errors == 0 && expected_rsp.size() == 0) begin
            $display("[buddy_page_allocator_unit] OK");
        end else begin
            $display("[buddy_page_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/buddy_page_allocator_unit.sv
dv/testbench.sv
